@@ rtl/lrcf_pkg.sv @@
// Shared types and constants for the LED ring frame buffer with blinking cursor.
// Used by lrcf_ctrl, lrcf_datapath and led_ring_cursor_framebuffer; no dependencies.
package lrcf_pkg;

    localparam int PIXEL_COUNT_DEF = 12;

    // Field widths
    localparam int OP_W      = 3;
    localparam int IDX_IN_W  = 7;
    localparam int COLOUR_W  = 24;
    localparam int DIR_W     = 2;
    localparam int NUM_W     = 6;
    localparam int PERIOD_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam int PHASE_STEPS = 4;
    localparam int PHASE_W     = $clog2(PHASE_STEPS);

    localparam logic [COLOUR_W-1:0] GREY_COLOUR  = 24'h404040;
    localparam logic [COLOUR_W-1:0] BLACK_COLOUR = 24'h000000;
    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 16'd500;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_PIXEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL       = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE       = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_OFFSET   = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic exec;        // input transaction accepted this cycle
        logic scan_issue;  // read the next pixel of a scan
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tick_scan;   // a tick now would start a scan
        logic s1_busy;     // read stage holds a pixel
        logic s1_free;     // read stage can take a pixel this cycle
        logic out_free;    // output register can take a result this cycle
        logic scan_at_end; // scan address is on the last pixel
    } dp_status_t;

endpackage

@@ rtl/led_ring_cursor_framebuffer.sv @@
// Top level of the LED ring frame buffer with blinking cursor.
// Joins lrcf_ctrl and lrcf_datapath; depends on lrcf_pkg.
//
// Usage:
//   s_* channel carries commands: tick, set pixel, fill, set cursor, move cursor.
//   m_* channel returns results: one status per move (m_kind 0, m_last 1), and
//   PIXEL_COUNT scanned-out pixels (m_kind 1) on a tick that follows a change
//   or that advances the blink phase, in physical order, m_last on the final one.
//   cfg_* writes blink_period (index 0) and top_offset (index 1); always ready,
//   to be written only while the block is idle.
// Flow:
//   A move status is on m_* the cycle after its transaction. A scanning tick
//   passes its pixels through the read stage and the output register, one pixel
//   per cycle while m_ready is high, from the pixel memory's single read port;
//   the next command is taken once the last pixel is in the output register
//   and leaving it. Other commands are taken one per cycle while the output is free.
// Reset (aresetn low, synchronous): all pixels black, cursor off, blink_period
//   500, top_offset 0, and the first tick scans out the whole ring.
// Stall: with m_ready low the output register and the read stage hold their
//   pixels and the scan pauses; nothing is dropped.
module led_ring_cursor_framebuffer #(
    parameter int PIXEL_COUNT = lrcf_pkg::PIXEL_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [lrcf_pkg::OP_W-1:0]              s_operation,
    input  logic signed [lrcf_pkg::IDX_IN_W-1:0]   s_index,
    input  logic [lrcf_pkg::COLOUR_W-1:0]          s_colour,
    input  logic signed [lrcf_pkg::DIR_W-1:0]      s_direction,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_kind,
    output logic [lrcf_pkg::NUM_W-1:0]             m_pixel_number,
    output logic [lrcf_pkg::COLOUR_W-1:0]          m_pixel_colour,
    output logic                                   m_last,
    output logic                                   m_moved,
    output logic                                   m_cursor_on,
    output logic [lrcf_pkg::NUM_W-1:0]             m_cursor_display_index,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lrcf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lrcf_pkg::PERIOD_W-1:0]          cfg_data
);

    lrcf_pkg::ctrl_cmd_t  cmd;
    lrcf_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lrcf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    lrcf_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .status                 (status),
        .s_operation            (s_operation),
        .s_index                (s_index),
        .s_colour               (s_colour),
        .s_direction            (s_direction),
        .cfg_valid              (cfg_valid),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_pixel_number         (m_pixel_number),
        .m_pixel_colour         (m_pixel_colour),
        .m_last                 (m_last),
        .m_moved                (m_moved),
        .m_cursor_on            (m_cursor_on),
        .m_cursor_display_index (m_cursor_display_index)
    );

endmodule

@@ rtl/lrcf_ctrl.sv @@
// Controller for the LED ring frame buffer: idle/scan state machine that
// accepts input transactions and paces the scan-out. Depends on lrcf_pkg.
module lrcf_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [lrcf_pkg::OP_W-1:0]    s_operation,
    output logic                         s_ready,
    input  lrcf_pkg::dp_status_t         status,
    output lrcf_pkg::ctrl_cmd_t          cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        s_ready        = (state_reg == ST_IDLE) && !status.s1_busy && status.out_free;
        cmd.exec       = s_valid && s_ready;
        cmd.scan_issue = (state_reg == ST_SCAN) && status.s1_free;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.exec && s_operation == lrcf_pkg::OP_TICK && status.tick_scan) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmd.scan_issue && status.scan_at_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/lrcf_datapath.sv @@
// Datapath for the LED ring frame buffer: pixel memory, cursor and blink state,
// configuration registers, scan read stage and output register. Depends on lrcf_pkg.
module lrcf_datapath #(
    parameter int PIXEL_COUNT = lrcf_pkg::PIXEL_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lrcf_pkg::ctrl_cmd_t                    cmd,
    output lrcf_pkg::dp_status_t                   status,
    input  logic [lrcf_pkg::OP_W-1:0]              s_operation,
    input  logic signed [lrcf_pkg::IDX_IN_W-1:0]   s_index,
    input  logic [lrcf_pkg::COLOUR_W-1:0]          s_colour,
    input  logic signed [lrcf_pkg::DIR_W-1:0]      s_direction,
    input  logic                                   cfg_valid,
    input  logic [lrcf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lrcf_pkg::PERIOD_W-1:0]          cfg_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_kind,
    output logic [lrcf_pkg::NUM_W-1:0]             m_pixel_number,
    output logic [lrcf_pkg::COLOUR_W-1:0]          m_pixel_colour,
    output logic                                   m_last,
    output logic                                   m_moved,
    output logic                                   m_cursor_on,
    output logic [lrcf_pkg::NUM_W-1:0]             m_cursor_display_index
);

    localparam int IdxW   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int SumW   = IdxW + 1;
    localparam int OffCnt = 2 ** lrcf_pkg::NUM_W;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(PIXEL_COUNT - 1);
    localparam logic [SumW-1:0] CountS  = SumW'(PIXEL_COUNT);

    // Offset reduced modulo the ring size, one entry per possible offset
    logic [IdxW-1:0] top_mod_lut [OffCnt];
    for (genvar g = 0; g < OffCnt; g++) begin : g_top_mod
        assign top_mod_lut[g] = IdxW'(g % PIXEL_COUNT);
    end

    logic [lrcf_pkg::PERIOD_W-1:0] period_reg;
    logic [IdxW-1:0]               top_eff_reg;
    logic [lrcf_pkg::COLOUR_W-1:0] fill_colour_reg;
    logic [PIXEL_COUNT-1:0]        entry_valid_reg;
    logic                          cursor_en_reg;
    logic [IdxW-1:0]               cursor_phys_reg;
    logic [lrcf_pkg::PERIOD_W-1:0] timer_reg;
    logic [lrcf_pkg::PHASE_W-1:0]  phase_reg;
    logic                          changed_reg;
    logic [IdxW-1:0]               scan_addr_reg;

    logic [lrcf_pkg::COLOUR_W-1:0] pixel_mem [PIXEL_COUNT];
    logic [lrcf_pkg::COLOUR_W-1:0] rd_data_reg;
    logic                          s1_valid_reg;
    logic                          s1_hit_reg;
    logic [IdxW-1:0]               s1_num_reg;
    logic                          s1_last_reg;

    logic                          out_valid_reg;
    logic                          out_kind_reg;
    logic [lrcf_pkg::NUM_W-1:0]    out_num_reg;
    logic [lrcf_pkg::COLOUR_W-1:0] out_colour_reg;
    logic                          out_last_reg;
    logic                          out_moved_reg;
    logic                          out_cursor_on_reg;
    logic [lrcf_pkg::NUM_W-1:0]    out_disp_reg;

    logic                          idx_in_range;
    logic [IdxW-1:0]               idx_disp;
    logic [SumW-1:0]               phys_sum;
    logic [IdxW-1:0]               idx_phys;
    logic                          move_ok;
    logic [IdxW-1:0]               cursor_step;
    logic [IdxW-1:0]               cursor_after;
    logic [SumW-1:0]               disp_sum;
    logic [IdxW-1:0]               cursor_disp;
    logic [lrcf_pkg::PERIOD_W-1:0] timer_inc;
    logic                          period_hit;
    logic                          mem_we;
    logic                          out_load;
    logic                          move_exec;
    logic                          cursor_hit;
    logic [lrcf_pkg::COLOUR_W-1:0] base_colour;
    logic [lrcf_pkg::COLOUR_W-1:0] scan_colour;

    always_comb begin
        // Display index to physical pixel
        idx_in_range = !s_index[lrcf_pkg::IDX_IN_W-1] &&
                       ($unsigned(s_index) < lrcf_pkg::IDX_IN_W'(PIXEL_COUNT));
        idx_disp     = s_index[IdxW-1:0];
        phys_sum     = {1'b0, idx_disp} + {1'b0, top_eff_reg};
        idx_phys     = (phys_sum >= CountS) ? IdxW'(phys_sum - CountS) : IdxW'(phys_sum);

        // One step around the ring; direction -2 counts as anticlockwise
        move_ok = cursor_en_reg && (s_direction != '0);
        if (s_direction == lrcf_pkg::DIR_W'(1)) begin
            cursor_step = (cursor_phys_reg == LastIdx) ? '0 : cursor_phys_reg + 1'b1;
        end else begin
            cursor_step = (cursor_phys_reg == '0) ? LastIdx : cursor_phys_reg - 1'b1;
        end
        cursor_after = move_ok ? cursor_step : cursor_phys_reg;
        disp_sum     = {1'b0, cursor_after} + CountS - {1'b0, top_eff_reg};
        cursor_disp  = (disp_sum >= CountS) ? IdxW'(disp_sum - CountS) : IdxW'(disp_sum);

        // Blink timer saturates at its top value
        timer_inc  = (timer_reg == '1) ? timer_reg : timer_reg + 1'b1;
        period_hit = cursor_en_reg && (timer_inc >= period_reg);

        mem_we    = cmd.exec && (s_operation == lrcf_pkg::OP_SET_PIXEL) && idx_in_range;
        move_exec = cmd.exec && (s_operation == lrcf_pkg::OP_MOVE);

        status.tick_scan   = changed_reg || period_hit;
        status.s1_busy     = s1_valid_reg;
        status.out_free    = !out_valid_reg || m_ready;
        out_load           = s1_valid_reg && status.out_free;
        status.s1_free     = !s1_valid_reg || out_load;
        status.scan_at_end = (scan_addr_reg == LastIdx);

        // Cursor overlay during blink phase 0
        base_colour = s1_hit_reg ? rd_data_reg : fill_colour_reg;
        cursor_hit  = cursor_en_reg && (s1_num_reg == cursor_phys_reg) && (phase_reg == '0);
        if (cursor_hit) begin
            scan_colour = (base_colour != '0) ? lrcf_pkg::BLACK_COLOUR
                                              : lrcf_pkg::GREY_COLOUR;
        end else begin
            scan_colour = base_colour;
        end
    end

    // Configuration, cursor and blink state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= lrcf_pkg::BLINK_PERIOD_RESET;
            top_eff_reg     <= '0;
            fill_colour_reg <= lrcf_pkg::BLACK_COLOUR;
            entry_valid_reg <= '0;
            cursor_en_reg   <= 1'b0;
            cursor_phys_reg <= '0;
            timer_reg       <= '0;
            phase_reg       <= '0;
            changed_reg     <= 1'b1;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    lrcf_pkg::CFG_BLINK_PERIOD: period_reg <= cfg_data;
                    lrcf_pkg::CFG_TOP_OFFSET:
                        top_eff_reg <= top_mod_lut[cfg_data[lrcf_pkg::NUM_W-1:0]];
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                unique case (s_operation)
                    lrcf_pkg::OP_TICK: begin
                        if (changed_reg) begin
                            timer_reg <= '0;
                            phase_reg <= '0;
                        end else if (cursor_en_reg) begin
                            if (period_hit) begin
                                timer_reg <= '0;
                                phase_reg <= phase_reg + 1'b1;
                            end else begin
                                timer_reg <= timer_inc;
                            end
                        end
                        // a scan, if any, clears the flag
                        changed_reg <= 1'b0;
                    end
                    lrcf_pkg::OP_SET_PIXEL: begin
                        if (idx_in_range) begin
                            entry_valid_reg[idx_phys] <= 1'b1;
                            changed_reg               <= 1'b1;
                        end
                    end
                    lrcf_pkg::OP_FILL: begin
                        // invalid entries read as the fill colour
                        entry_valid_reg <= '0;
                        fill_colour_reg <= s_colour;
                        changed_reg     <= 1'b1;
                    end
                    lrcf_pkg::OP_SET_CURSOR: begin
                        if (s_index[lrcf_pkg::IDX_IN_W-1]) begin
                            cursor_en_reg <= 1'b0;
                            changed_reg   <= 1'b1;
                        end else if (idx_in_range) begin
                            cursor_en_reg   <= 1'b1;
                            cursor_phys_reg <= idx_phys;
                            changed_reg     <= 1'b1;
                        end
                    end
                    lrcf_pkg::OP_MOVE: begin
                        if (move_ok) begin
                            cursor_phys_reg <= cursor_step;
                            changed_reg     <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Pixel memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[idx_phys] <= s_colour;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= pixel_mem[scan_addr_reg];
        end
    end

    // Scan address and read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (cmd.exec) begin
                scan_addr_reg <= '0;
            end else if (cmd.scan_issue) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (cmd.scan_issue) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_issue) begin
            s1_hit_reg  <= entry_valid_reg[scan_addr_reg];
            s1_num_reg  <= scan_addr_reg;
            s1_last_reg <= (scan_addr_reg == LastIdx);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load || move_exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg      <= 1'b1;
            out_num_reg       <= lrcf_pkg::NUM_W'(s1_num_reg);
            out_colour_reg    <= scan_colour;
            out_last_reg      <= s1_last_reg;
            out_moved_reg     <= 1'b0;
            out_cursor_on_reg <= 1'b0;
            out_disp_reg      <= '0;
        end else if (move_exec) begin
            out_kind_reg      <= 1'b0;
            out_num_reg       <= '0;
            out_colour_reg    <= '0;
            out_last_reg      <= 1'b1;
            out_moved_reg     <= move_ok;
            out_cursor_on_reg <= cursor_en_reg;
            out_disp_reg      <= cursor_en_reg ? lrcf_pkg::NUM_W'(cursor_disp) : '0;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_kind                 = out_kind_reg;
    assign m_pixel_number         = out_num_reg;
    assign m_pixel_colour         = out_colour_reg;
    assign m_last                 = out_last_reg;
    assign m_moved                = out_moved_reg;
    assign m_cursor_on            = out_cursor_on_reg;
    assign m_cursor_display_index = out_disp_reg;

    a_no_load_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !cmd.exec)
        else $error("scan pixel and status result loaded together");

    a_read_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !status.out_free |=> s1_valid_reg && $stable(s1_num_reg))
        else $error("stalled scan pixel lost");

    a_cursor_on_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_phys_reg <= LastIdx)
        else $error("cursor off the ring");

    a_fill_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && s_operation == lrcf_pkg::OP_FILL |=> entry_valid_reg == '0)
        else $error("fill left stored pixels visible");

endmodule
